[rtl/core/data_eeprom_controller_defines.svh]
// Assertion macros shared by the data EEPROM controller modules.
`ifndef DATA_EEPROM_CONTROLLER_DEFINES_SVH
`define DATA_EEPROM_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define DEEC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deec check failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define DEEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deec check failed: next-cycle implication");

`else

`define DEEC_ASSERT_NOW(label, ante, cons)
`define DEEC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/core/deec_pkg.sv]
// Types and constants of the data EEPROM controller.
package deec_pkg;

  // Access kinds carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  // Register selects
  typedef enum logic [1:0] {
    REG_CTRL   = 2'd0,
    REG_UNLOCK = 2'd1,
    REG_ADDR   = 2'd2,
    REG_DATA   = 2'd3
  } reg_sel_t;

  // Unlock sequence progress
  typedef enum logic [1:0] {
    UNL_IDLE  = 2'd0,
    UNL_FIRST = 2'd1,
    UNL_ARMED = 2'd2
  } unlock_t;

  // Controller states
  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } state_t;

  // Control register bit positions
  localparam int unsigned CTL_RD_BIT   = 0;
  localparam int unsigned CTL_WR_BIT   = 1;
  localparam int unsigned CTL_WREN_BIT = 2;

  // Bits kept in the control register (WR and RD are not stored)
  localparam logic [7:0] CTL_KEEP_MASK = 8'hFC;

  // Unlock key bytes
  localparam logic [7:0] UNLOCK_FIRST  = 8'h55;
  localparam logic [7:0] UNLOCK_SECOND = 8'hAA;

  // Value of an erased byte
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  // Controller to datapath
  typedef struct packed {
    logic take;        // input transaction accepted this cycle
    logic fetch_load;  // memory read data is valid, load data register
  } deec_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rd_req;      // current input needs a memory read
  } deec_status_t;

endpackage

[rtl/core/deec_mem.sv]
// Byte store with per-entry valid bits and a registered read port.
module deec_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IDX_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  output logic [7:0]       rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]       rdata;
  logic             rvalid;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Mark written entries; reset makes every entry read as erased
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else if (rd_en) begin
      rvalid <= valid[rd_addr];
    end
  end

  assign rd_data = rvalid ? rdata : deec_pkg::ERASED_BYTE;

endmodule

[rtl/core/deec_dp.sv]
// Register file, unlock tracking, write timer and result registers.
`include "data_eeprom_controller_defines.svh"

module deec_dp #(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned WRITE_TICKS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             func,
  input  logic [1:0]             reg_sel,
  input  logic [7:0]             write_value,
  input  deec_pkg::deec_cmd_t    cmd,
  output deec_pkg::deec_status_t status,
  output logic [7:0]             read_value,
  output logic                   write_busy
);

  localparam int unsigned IDX_W   = $clog2(STORE_DEPTH);
  localparam logic [11:0] DEPTH12 = 12'(STORE_DEPTH);
  localparam logic [7:0]  TICKS8  = 8'(WRITE_TICKS);

  logic [7:0]        address_reg;
  logic [IDX_W-1:0]  addr_idx;
  logic [IDX_W-1:0]  addr_idx_next;
  logic [7:0]        data_reg;
  logic [7:0]        control_bits;
  deec_pkg::unlock_t unlock_stage;
  deec_pkg::unlock_t unlock_stage_next;
  logic [7:0]        countdown;
  logic [7:0]        countdown_next;
  logic              mem_we;
  logic [7:0]        mem_rdata;
  logic [7:0]        reg_rd;
  logic              is_read;
  logic              is_write;
  logic              is_tick;
  logic              ctl_wr_hit;

  // Decode the access
  assign is_read  = (func == deec_pkg::FUNC_READ);
  assign is_write = (func == deec_pkg::FUNC_WRITE);
  assign is_tick  = (func == deec_pkg::FUNC_TICK);
  assign ctl_wr_hit = is_write && (reg_sel == deec_pkg::REG_CTRL);
  assign status.rd_req = ctl_wr_hit && write_value[deec_pkg::CTL_RD_BIT];

  // Reduce a new address modulo the store depth by restoring steps
  always_comb begin
    logic [11:0] rem;
    rem = {4'b0000, write_value};
    for (int k = 3; k >= 0; k--) begin
      if (rem >= (DEPTH12 << k)) begin
        rem = rem - (DEPTH12 << k);
      end
    end
    addr_idx_next = rem[IDX_W-1:0];
  end

  // Advance the write timer; start it on an unlocked, enabled WR
  always_comb begin
    countdown_next = countdown;
    mem_we         = 1'b0;
    if (cmd.take) begin
      if (is_tick && countdown != 8'd0) begin
        countdown_next = countdown - 8'd1;
        mem_we         = (countdown == 8'd1);
      end else if (ctl_wr_hit && write_value[deec_pkg::CTL_WR_BIT] &&
                   write_value[deec_pkg::CTL_WREN_BIT] &&
                   unlock_stage == deec_pkg::UNL_ARMED && countdown == 8'd0) begin
        countdown_next = TICKS8;
      end
    end
  end

  // Track the unlock key sequence
  always_comb begin
    unlock_stage_next = unlock_stage;
    if (cmd.take) begin
      if (is_read) begin
        unlock_stage_next = deec_pkg::UNL_IDLE;
      end else if (is_write) begin
        if (reg_sel == deec_pkg::REG_UNLOCK) begin
          if (write_value == deec_pkg::UNLOCK_FIRST) begin
            unlock_stage_next = deec_pkg::UNL_FIRST;
          end else if (write_value == deec_pkg::UNLOCK_SECOND &&
                       unlock_stage == deec_pkg::UNL_FIRST) begin
            unlock_stage_next = deec_pkg::UNL_ARMED;
          end else begin
            unlock_stage_next = deec_pkg::UNL_IDLE;
          end
        end else begin
          unlock_stage_next = deec_pkg::UNL_IDLE;
        end
      end
    end
  end

  // Register readback
  always_comb begin
    reg_rd = 8'h00;
    unique case (deec_pkg::reg_sel_t'(reg_sel))
      deec_pkg::REG_CTRL: begin
        reg_rd = control_bits;
        reg_rd[deec_pkg::CTL_WR_BIT] = (countdown != 8'd0);
      end
      deec_pkg::REG_UNLOCK: reg_rd = 8'h00;
      deec_pkg::REG_ADDR:   reg_rd = address_reg;
      deec_pkg::REG_DATA:   reg_rd = data_reg;
      default:              reg_rd = 8'h00;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      address_reg  <= 8'h00;
      addr_idx     <= '0;
      data_reg     <= 8'h00;
      control_bits <= 8'h00;
      unlock_stage <= deec_pkg::UNL_IDLE;
      countdown    <= 8'h00;
    end else begin
      unlock_stage <= unlock_stage_next;
      countdown    <= countdown_next;
      if (cmd.take && is_write) begin
        unique case (deec_pkg::reg_sel_t'(reg_sel))
          deec_pkg::REG_CTRL:   control_bits <= write_value & deec_pkg::CTL_KEEP_MASK;
          deec_pkg::REG_UNLOCK: ;
          deec_pkg::REG_ADDR: begin
            address_reg <= write_value;
            addr_idx    <= addr_idx_next;
          end
          deec_pkg::REG_DATA:   data_reg <= write_value;
          default: ;
        endcase
      end
      if (cmd.fetch_load) begin
        data_reg <= mem_rdata;
      end
    end
  end

  // Result payload, captured with the input transaction
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      read_value <= is_read ? reg_rd : 8'h00;
      write_busy <= (countdown_next != 8'd0);
    end
  end

  deec_mem #(
    .DEPTH (STORE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (cmd.take && status.rd_req),
    .rd_addr (addr_idx),
    .wr_en   (mem_we),
    .wr_addr (addr_idx),
    .wr_data (data_reg),
    .rd_data (mem_rdata)
  );

  `DEEC_ASSERT_NOW(a_timer_range, 1'b1, countdown <= TICKS8)
  `DEEC_ASSERT_NOW(a_store_only_on_expiry, mem_we, is_tick && countdown == 8'd1)

endmodule

[rtl/core/deec_ctrl.sv]
// Controller: input/output handshake and memory fetch sequencing.
`include "data_eeprom_controller_defines.svh"

module deec_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  deec_pkg::deec_status_t status,
  output deec_pkg::deec_cmd_t    cmd
);

  deec_pkg::state_t state;
  deec_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deec_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    cmd.take       = 1'b0;
    cmd.fetch_load = 1'b0;
    unique case (state)
      deec_pkg::ST_IDLE: begin
        s_tready = !m_tvalid || m_tready;
        cmd.take = s_tvalid && s_tready;
        if (cmd.take && status.rd_req) begin
          state_next = deec_pkg::ST_FETCH;
        end
      end
      deec_pkg::ST_FETCH: begin
        cmd.fetch_load = 1'b1;
        state_next     = deec_pkg::ST_IDLE;
      end
      default: state_next = deec_pkg::ST_IDLE;
    endcase
  end

  // Output valid: set on accept, drop once the result transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `DEEC_ASSERT_NEXT(a_fetch_one_cycle, state == deec_pkg::ST_FETCH, state == deec_pkg::ST_IDLE)
  `DEEC_ASSERT_NOW(a_fetch_has_result, state == deec_pkg::ST_FETCH, m_tvalid)

endmodule

[rtl/core/data_eeprom_controller.sv]
// Data EEPROM controller: control, unlock, address and data registers over a byte store, one
// register access or time tick per input transaction and one result per access. A control
// write with the read bit set also passes through a fetch state, because the store's read
// port is registered and the data register loads in the following cycle. A write starts only
// with write-enable set and 0x55 then 0xAA just written to the unlock register; it stores the
// data byte WRITE_TICKS tick transactions later. The store reads as 0xFF until written; valid
// bits per entry clear at reset, so no clearing pass is needed. Addresses wrap modulo
// STORE_DEPTH. A new transaction is taken while the previous result is being handed off.
module data_eeprom_controller #(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned WRITE_TICKS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] write_value
  input  logic [3:0]  s_tuser,   // [1:0] func, [3:2] reg_sel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] read_value, [8] write_busy, [15:9] zero
);

  deec_pkg::deec_cmd_t    cmd;
  deec_pkg::deec_status_t status;
  logic [7:0]             read_value;
  logic                   write_busy;

  deec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  deec_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .WRITE_TICKS (WRITE_TICKS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .func        (s_tuser[1:0]),
    .reg_sel     (s_tuser[3:2]),
    .write_value (s_tdata),
    .cmd         (cmd),
    .status      (status),
    .read_value  (read_value),
    .write_busy  (write_busy)
  );

  // Pack the result
  assign m_tdata = {7'b0000000, write_busy, read_value};

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the data EEPROM controller: register mirror plus stream drivers.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned WRITE_TICKS = 4;

  // One reply as the block hands it back
  typedef struct packed {
    logic [7:0] read_value;
    logic       write_busy;
  } reply_t;

  // Register-level mirror of the controller with the queue of replies it owes
  class eeprom_mirror;
    logic [7:0]        cells [STORE_DEPTH];
    logic [7:0]        addr_q;
    logic [7:0]        data_q;
    logic [7:0]        ctrl_q;
    deec_pkg::unlock_t stage;
    int unsigned       countdown;
    reply_t            expected_replies [$];
    int unsigned       failures;
    int unsigned       replies_checked;
    int unsigned       commits;
    int unsigned       loads;
    int unsigned       accesses;

    function new();
      foreach (cells[i]) cells[i] = deec_pkg::ERASED_BYTE;
      addr_q = '0;
      data_q = '0;
      ctrl_q = '0;
      stage = deec_pkg::UNL_IDLE;
      countdown = 0;
      failures = 0;
      replies_checked = 0;
      commits = 0;
      loads = 0;
      accesses = 0;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    // Apply one accepted access and queue the reply it owes
    function void take_access(deec_pkg::func_t f, deec_pkg::reg_sel_t s, logic [7:0] v);
      reply_t r;
      logic   armed;
      r.read_value = '0;
      armed = (stage == deec_pkg::UNL_ARMED);
      accesses++;
      case (f)
        deec_pkg::FUNC_READ: begin
          case (s)
            deec_pkg::REG_CTRL: begin
              r.read_value = ctrl_q;
              r.read_value[deec_pkg::CTL_WR_BIT] = (countdown != 0);
            end
            deec_pkg::REG_ADDR: r.read_value = addr_q;
            deec_pkg::REG_DATA: r.read_value = data_q;
            default:            r.read_value = '0;
          endcase
          stage = deec_pkg::UNL_IDLE;
        end
        deec_pkg::FUNC_WRITE: begin
          case (s)
            deec_pkg::REG_CTRL: begin
              ctrl_q = v & deec_pkg::CTL_KEEP_MASK;
              if (v[deec_pkg::CTL_RD_BIT]) begin
                data_q = cells[addr_q % STORE_DEPTH];
                loads++;
              end
              if (v[deec_pkg::CTL_WR_BIT] && v[deec_pkg::CTL_WREN_BIT] && armed &&
                  countdown == 0)
                countdown = WRITE_TICKS;
              stage = deec_pkg::UNL_IDLE;
            end
            deec_pkg::REG_UNLOCK: begin
              if (v == deec_pkg::UNLOCK_FIRST) stage = deec_pkg::UNL_FIRST;
              else if (v == deec_pkg::UNLOCK_SECOND && stage == deec_pkg::UNL_FIRST)
                stage = deec_pkg::UNL_ARMED;
              else stage = deec_pkg::UNL_IDLE;
            end
            deec_pkg::REG_ADDR: begin
              addr_q = v;
              stage = deec_pkg::UNL_IDLE;
            end
            default: begin
              data_q = v;
              stage = deec_pkg::UNL_IDLE;
            end
          endcase
        end
        deec_pkg::FUNC_TICK: begin
          if (countdown != 0) begin
            countdown--;
            if (countdown == 0) begin
              cells[addr_q % STORE_DEPTH] = data_q;
              commits++;
            end
          end
        end
        default: ;
      endcase
      r.write_busy = (countdown != 0);
      expected_replies.push_back(r);
    endfunction

    // Compare one reply against the oldest one owed
    function void match_reply(logic [7:0] rv, logic busy);
      reply_t e;
      replies_checked++;
      if (expected_replies.size() == 0) begin
        if (failures < 10)
          $display("ERROR: unexpected reply read_value=%02h write_busy=%0b", rv, busy);
        failures++;
        return;
      end
      e = expected_replies.pop_front();
      if (rv !== e.read_value || busy !== e.write_busy) begin
        if (failures < 10)
          $display("ERROR: reply %0d: read_value exp %02h got %02h, write_busy exp %0b got %0b",
                   replies_checked, e.read_value, rv, e.write_busy, busy);
        failures++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  eeprom_mirror sb = new();

  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 58;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;
  logic [7:0]  addr_pool [8];

  data_eeprom_controller #(
    .STORE_DEPTH(STORE_DEPTH),
    .WRITE_TICKS(WRITE_TICKS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Give up if the run hangs
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Drive tready: one long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      m_tready <= 1'b0;
      hold_left <= 120;
      hold_taken <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Note accepted accesses first, then check replies of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.take_access(deec_pkg::func_t'(s_tuser[1:0]),
                       deec_pkg::reg_sel_t'(s_tuser[3:2]), s_tdata);
      if (m_tvalid && m_tready)
        sb.match_reply(m_tdata[7:0], m_tdata[8]);
    end
  end

  // Offer one access and hold it until accepted
  task automatic send_access(input deec_pkg::func_t f, input deec_pkg::reg_sel_t s,
                             input logic [7:0] v);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {s, f};
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Pause the sender until every reply owed has come back
  task automatic wait_all_replies();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] pick_addr();
    if ($urandom_range(0, 99) < 75) return addr_pool[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  // Random access of any kind, biased toward the unlock keys
  task automatic send_noise();
    deec_pkg::func_t f;
    logic [7:0]      v;
    f = ($urandom_range(0, 99) < 3) ? deec_pkg::FUNC_NOP
                                    : deec_pkg::func_t'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0, 1:    v = deec_pkg::UNLOCK_FIRST;
      2:       v = deec_pkg::UNLOCK_SECOND;
      default: v = 8'($urandom);
    endcase
    send_access(f, deec_pkg::reg_sel_t'($urandom_range(0, 3)), v);
  endtask

  // Address, data, unlock keys, start bit, then ticks mixed with other traffic
  task automatic run_write_sequence();
    logic [7:0] ctl;
    int         n;
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_ADDR, pick_addr());
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_DATA, 8'($urandom));
    if ($urandom_range(0, 99) < 88)
      send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_UNLOCK, deec_pkg::UNLOCK_FIRST);
    else send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_UNLOCK, 8'($urandom));
    if ($urandom_range(0, 99) < 88)
      send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_UNLOCK, deec_pkg::UNLOCK_SECOND);
    else send_noise();
    ctl = 8'($urandom);
    ctl[deec_pkg::CTL_WR_BIT] = 1'b1;
    ctl[deec_pkg::CTL_WREN_BIT] = ($urandom_range(0, 99) < 90);
    ctl[deec_pkg::CTL_RD_BIT] = ($urandom_range(0, 99) < 15);
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_CTRL, ctl);
    n = $urandom_range(0, 7);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: send_access(deec_pkg::FUNC_READ, deec_pkg::reg_sel_t'($urandom_range(0, 3)),
                       8'($urandom));
        1: send_noise();
        default: send_access(deec_pkg::FUNC_TICK,
                             deec_pkg::reg_sel_t'($urandom_range(0, 3)), 8'($urandom));
      endcase
    end
  endtask

  // Load a byte into the data register and read it back
  task automatic run_readback();
    logic [7:0] ctl;
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_ADDR, pick_addr());
    ctl = 8'($urandom);
    ctl[deec_pkg::CTL_RD_BIT] = 1'b1;
    ctl[deec_pkg::CTL_WR_BIT] = ($urandom_range(0, 99) < 20);
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_CTRL, ctl);
    send_access(deec_pkg::FUNC_READ, deec_pkg::REG_DATA, 8'($urandom));
    if ($urandom_range(0, 1) == 0)
      send_access(deec_pkg::FUNC_READ, deec_pkg::REG_CTRL, 8'($urandom));
  endtask

  task automatic run_random(input int unsigned count, input bit with_hold);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if (with_hold && !hold_req && items_sent + count / 2 >= stop_at) hold_req <= 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: run_write_sequence();
        4, 5:       run_readback();
        default:    send_noise();
      endcase
    end
  endtask

  // Stimulus: reset, directed accesses, then three random phases
  initial begin
    foreach (addr_pool[i]) addr_pool[i] = 8'($urandom);
    addr_pool[0] = 8'h00;
    addr_pool[1] = 8'hFF;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values of every register
    send_access(deec_pkg::FUNC_READ, deec_pkg::REG_CTRL, 8'h00);
    send_access(deec_pkg::FUNC_READ, deec_pkg::REG_UNLOCK, 8'hFF);
    send_access(deec_pkg::FUNC_READ, deec_pkg::REG_ADDR, 8'h00);
    send_access(deec_pkg::FUNC_READ, deec_pkg::REG_DATA, 8'h00);
    // Erased byte at the top address
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_ADDR, 8'hFF);
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_CTRL, 8'h01);
    send_access(deec_pkg::FUNC_READ, deec_pkg::REG_DATA, 8'h00);
    // Unlocked write with every other control bit set, read the busy flag
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_DATA, 8'h00);
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_UNLOCK, deec_pkg::UNLOCK_FIRST);
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_UNLOCK, deec_pkg::UNLOCK_SECOND);
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_CTRL, 8'hFE);
    send_access(deec_pkg::FUNC_READ, deec_pkg::REG_CTRL, 8'h00);
    // Second start while busy is ignored, address moves before completion
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_UNLOCK, deec_pkg::UNLOCK_FIRST);
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_UNLOCK, deec_pkg::UNLOCK_SECOND);
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_CTRL, 8'h06);
    send_access(deec_pkg::FUNC_TICK, deec_pkg::REG_CTRL, 8'h00);
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_ADDR, 8'h00);
    send_access(deec_pkg::FUNC_NOP, deec_pkg::REG_DATA, 8'hFF);
    repeat (3) send_access(deec_pkg::FUNC_TICK, deec_pkg::REG_DATA, 8'hFF);
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_CTRL, 8'h01);
    send_access(deec_pkg::FUNC_READ, deec_pkg::REG_DATA, 8'h00);
    // Unlock broken by a read of the unlock register, start is ignored
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_UNLOCK, deec_pkg::UNLOCK_FIRST);
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_UNLOCK, deec_pkg::UNLOCK_SECOND);
    send_access(deec_pkg::FUNC_READ, deec_pkg::REG_UNLOCK, 8'h00);
    send_access(deec_pkg::FUNC_WRITE, deec_pkg::REG_CTRL, 8'h06);
    wait_all_replies();

    run_random(510, 1'b1);
    wait_all_replies();
    send_idle_pct = 58;
    recv_idle_pct <= 15;
    run_random(510, 1'b0);
    wait_all_replies();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(510, 1'b0);

    // Drain and settle
    wait_all_replies();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("ERROR: %0d replies never arrived", sb.pending());
      sb.failures++;
    end

    $display("Covered %0d register accesses and ticks, %0d replies checked.",
             sb.accesses, sb.replies_checked);
    $display("Store writes committed: %0d, read-bit loads: %0d, mismatches: %0d.",
             sb.commits, sb.loads, sb.failures);
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
